@@ sv/efd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efd_pkg
// Types and constants shared by the escaped frame deframer modules.
// ---------------------------------------------------------------------------
package efd_pkg;

	localparam logic [7:0] ESC_BYTE   = 8'h1A;
	localparam logic [7:0] TYPE_SHORT = 8'h31;
	localparam logic [7:0] TYPE_LONG  = 8'h32;
	localparam logic [7:0] TYPE_EXT   = 8'h33;

	localparam logic [4:0] LEN_SHORT = 5'(2 + 7 + 2);
	localparam logic [4:0] LEN_LONG  = 5'(2 + 7 + 7);
	localparam logic [4:0] LEN_EXT   = 5'(2 + 7 + 14);
	localparam logic [4:0] LEN_NONE  = 5'd0;

	// Index of the first payload byte; bytes 0 and 1 are escape and type.
	localparam logic [4:0] FIRST_PAYLOAD = 5'd2;
	localparam logic [4:0] IDX_ESC       = 5'd0;
	localparam logic [4:0] IDX_TYPE      = 5'd1;

	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	typedef enum logic [1:0] {
		PM_HUNT,
		PM_TYPE,
		PM_DATA,
		PM_QUOTE
	} parse_mode_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SHOW
	} back_state_t;

	// One command from the parser to the frame buffer: store a payload byte
	// at its index, and start the burst when this byte completes the frame.
	typedef struct packed {
		logic [7:0] data;
		logic [4:0] idx;
		logic [1:0] kind;
		logic       emit;
	} store_cmd_t;

	function automatic logic [4:0] frame_len(input logic [7:0] type_byte);
		logic [4:0] len;
		unique case (type_byte)
			TYPE_SHORT: len = LEN_SHORT;
			TYPE_LONG:  len = LEN_LONG;
			TYPE_EXT:   len = LEN_EXT;
			default:    len = LEN_NONE;
		endcase
		return len;
	endfunction

endpackage

@@ sv/efd_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efd_queue
// Small first-in first-out queue of store commands between parser and buffer.
// ---------------------------------------------------------------------------
module efd_queue import efd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  store_cmd_t push_cmd,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output store_cmd_t head_cmd
);

	store_cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]       wr_ptr_q;
	logic [QUEUE_AW-1:0]       rd_ptr_q;
	logic [QUEUE_AW:0]         count_q;
	logic                      do_push;
	logic                      do_pop;

	assign full     = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

@@ sv/efd_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efd_front
// Byte parser: finds the escape and type bytes, removes escape doubling and
// issues store commands for payload bytes.
// ---------------------------------------------------------------------------
module efd_front import efd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       queue_full,
	output logic       push,
	output store_cmd_t push_cmd
);

	parse_mode_t mode_q, mode_d;
	logic [4:0]  count_q, count_d;
	logic [4:0]  expect_q, expect_d;
	logic [1:0]  kind_q, kind_d;
	logic        in_fire;
	logic        is_esc;
	logic [4:0]  type_len;
	logic [1:0]  type_kind;
	logic [4:0]  count_inc;

	assign in_stall  = queue_full;
	assign in_fire   = in_valid && !queue_full;
	assign is_esc    = (in_byte == ESC_BYTE);
	assign type_len  = frame_len(in_byte);
	assign type_kind = in_byte[1:0] - 2'd1;
	assign count_inc = count_q + 5'd1;

	// Next state and counters
	always_comb begin
		mode_d   = mode_q;
		count_d  = count_q;
		expect_d = expect_q;
		kind_d   = kind_q;
		if (in_fire) begin
			unique case (mode_q)
				PM_HUNT: begin
					if (is_esc) begin
						mode_d  = PM_TYPE;
						count_d = IDX_TYPE;
					end
				end
				PM_TYPE: begin
					if (type_len == LEN_NONE) begin
						mode_d = PM_HUNT;
					end else begin
						mode_d   = PM_DATA;
						count_d  = FIRST_PAYLOAD;
						expect_d = type_len;
						kind_d   = type_kind;
					end
				end
				PM_DATA: begin
					if (is_esc) begin
						mode_d = PM_QUOTE;
					end else begin
						count_d = count_inc;
						mode_d  = (count_inc == expect_q) ? PM_HUNT : PM_DATA;
					end
				end
				PM_QUOTE: begin
					if (is_esc) begin
						count_d = count_inc;
						mode_d  = (count_inc == expect_q) ? PM_HUNT : PM_DATA;
					end else if (type_len == LEN_NONE) begin
						// A lone escape followed by an unknown type byte drops the frame and hunts again.
						mode_d  = PM_HUNT;
						count_d = IDX_TYPE;
					end else begin
						mode_d   = PM_DATA;
						count_d  = FIRST_PAYLOAD;
						expect_d = type_len;
						kind_d   = type_kind;
					end
				end
				default: mode_d = PM_HUNT;
			endcase
		end
	end

	// Store commands
	always_comb begin
		push_cmd.data = in_byte;
		push_cmd.idx  = count_q;
		push_cmd.kind = kind_q;
		push_cmd.emit = (count_inc == expect_q);
		unique case (mode_q)
			PM_DATA:  push = in_fire && !is_esc;
			PM_QUOTE: push = in_fire && is_esc;
			default:  push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= PM_HUNT;
			count_q  <= '0;
			expect_q <= '0;
			kind_q   <= '0;
		end else begin
			mode_q   <= mode_d;
			count_q  <= count_d;
			expect_q <= expect_d;
			kind_q   <= kind_d;
		end
	end

endmodule

@@ sv/efd_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efd_back
// Frame buffer: stores payload bytes and replays a completed frame as a
// burst of output transfers.
// ---------------------------------------------------------------------------
module efd_back import efd_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 23
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       queue_empty,
	input  store_cmd_t head_cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [4:0] byte_index,
	output logic [1:0] frame_kind,
	output logic       last
);

	localparam int MEM_AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;

	logic [7:0]  frame_mem [MAX_FRAME_BYTES];
	back_state_t state_q, state_d;
	logic [4:0]  rd_idx_q;
	logic [4:0]  last_idx_q;
	logic [1:0]  kind_q;
	logic [7:0]  rd_data_q;
	logic        out_fire;
	logic        take_cmd;
	logic        wr_ok;

	assign out_fire = out_valid && !out_stall;
	assign take_cmd = pop && !queue_empty;
	assign wr_ok    = (int'(head_cmd.idx) < MAX_FRAME_BYTES);
	assign last     = (rd_idx_q == last_idx_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!queue_empty && head_cmd.emit) state_d = BK_READ;
			BK_READ: state_d = BK_SHOW;
			BK_SHOW: begin
				if (!out_stall) state_d = last ? BK_IDLE : BK_READ;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		pop       = (state_q == BK_IDLE);
		out_valid = (state_q == BK_SHOW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			rd_idx_q   <= '0;
			last_idx_q <= '0;
			kind_q     <= '0;
		end else begin
			state_q <= state_d;
			if (take_cmd && head_cmd.emit) begin
				rd_idx_q   <= IDX_ESC;
				last_idx_q <= head_cmd.idx;
				kind_q     <= head_cmd.kind;
			end else if (out_fire) begin
				rd_idx_q <= rd_idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_cmd && wr_ok) frame_mem[MEM_AW'(head_cmd.idx)] <= head_cmd.data;
		if (state_q == BK_READ) rd_data_q <= frame_mem[MEM_AW'(rd_idx_q)];
	end

	// The escape and type bytes are not stored; the escape byte is a constant and the type byte follows from the kind.
	always_comb begin
		byte_index = rd_idx_q;
		frame_kind = kind_q;
		priority if (rd_idx_q == IDX_ESC)  out_byte = ESC_BYTE;
		else if (rd_idx_q == IDX_TYPE)     out_byte = TYPE_SHORT + {6'd0, kind_q};
		else                               out_byte = rd_data_q;
	end

endmodule

@@ sv/escaped_frame_deframer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// escaped_frame_deframer
// Deframes an escaped byte stream into frames of 11, 16 or 23 bytes.
// The first byte of a frame is offered once its final store command has left
// the queue and the buffer has moved from its idle state through its read state.
// Throughput: one input byte per cycle while the 4-entry command queue has
// room; each output byte is fetched in the read state and held until taken.
// Reset clears the parser, queue and buffer control; the frame store holds
// no reset value and needs no clearing pass.
// ---------------------------------------------------------------------------
module escaped_frame_deframer import efd_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 23
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [4:0] byte_index,
	output logic [1:0] frame_kind,
	output logic       last
);

	store_cmd_t push_cmd;
	store_cmd_t head_cmd;
	logic       push;
	logic       pop;
	logic       queue_full;
	logic       queue_empty;

	efd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	efd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.head_cmd (head_cmd)
	);

	efd_back #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_index  (byte_index),
		.frame_kind  (frame_kind),
		.last        (last)
	);

endmodule
